FILE: rtl/vpwd_pkg.sv
// vpwd_pkg: shared types, constants and table functions of the voice program word decoder
// no dependencies; imported by vpwd_decode and voice_program_word_decoder
package vpwd_pkg;

   // one programming word is eight six-bit groups
   localparam int GROUP_W     = 6;
   localparam int GROUP_COUNT = 8;
   localparam int WORD_W      = GROUP_W * GROUP_COUNT;

   // special codes of the decode
   localparam logic [5:0]  ATTEN_SILENT   = 6'h3F;
   localparam logic [7:0]  FREQ_SPECIAL   = 8'hF0;
   localparam logic [7:0]  FREQ_ORDINARY  = 8'hFF;
   localparam logic [11:0] LEN_SHORT      = 12'd16;
   localparam logic [12:0] START_SHORT_OR = 13'h0010;

   // read methods with their own table shapes
   localparam logic [2:0] METH_QUAD_TWO  = 3'd2;
   localparam logic [2:0] METH_HALF_TWO  = 3'd4;
   localparam logic [2:0] METH_NARROW    = 3'd5;
   localparam logic [2:0] METH_QUARTER   = 3'd6;
   localparam logic [2:0] METH_NARROWEST = 3'd7;
   localparam logic [2:0] METH_DOUBLE    = 3'd0;
   localparam logic [2:0] LCODE_LONGEST  = 3'd7;

   // one decoded result transaction
   typedef struct packed {
      logic [3:0]  voice_number;
      logic        voice_active;
      logic [5:0]  attenuation;
      logic [7:0]  pitch_code;
      logic [3:0]  interpolation;
      logic [1:0]  output_pins;
      logic [12:0] first_start;
      logic [11:0] first_length;
      logic [2:0]  first_repeat;
      logic [12:0] second_start;
      logic [11:0] second_length;
      logic [2:0]  second_repeat;
   } rsp_fields_type;

   // table one length in samples
   function automatic logic [11:0] len_one(input logic [2:0] meth, input logic [2:0] lcode);
      logic [11:0] len;
      len = LEN_SHORT << lcode;
      if (meth == METH_QUAD_TWO && lcode == LCODE_LONGEST) begin
         len = 12'd1024;
      end
      return len;
   endfunction

   // table two length in samples
   function automatic logic [11:0] len_two(input logic [2:0] meth, input logic [2:0] lcode);
      logic [11:0] len;
      len = LEN_SHORT << lcode;
      case (meth)
         METH_QUAD_TWO: begin
            if (lcode == LCODE_LONGEST) begin
               len = 12'd1024;
            end
         end
         METH_HALF_TWO: begin
            len = 12'd8 << lcode;
         end
         METH_NARROW: begin
            len = (lcode < 3'd2) ? LEN_SHORT : (LEN_SHORT << (lcode - 3'd2));
         end
         METH_QUARTER: begin
            len = 12'd4 << lcode;
         end
         METH_NARROWEST: begin
            len = (lcode < 3'd3) ? LEN_SHORT : (LEN_SHORT << (lcode - 3'd3));
         end
         default: begin
            len = LEN_SHORT << lcode;
         end
      endcase
      return len;
   endfunction

   // reads per sample of table one
   function automatic logic [2:0] rep_one(input logic [2:0] meth);
      logic [2:0] rep;
      case (meth)
         METH_DOUBLE:   rep = 3'd2;
         METH_QUAD_TWO: rep = 3'd4;
         default:       rep = 3'd1;
      endcase
      return rep;
   endfunction

   // reads per sample of table two
   function automatic logic [2:0] rep_two(input logic [2:0] meth);
      logic [2:0] rep;
      case (meth)
         METH_DOUBLE:   rep = 3'd2;
         METH_QUAD_TWO: rep = 3'd4;
         METH_HALF_TWO: rep = 3'd2;
         METH_QUARTER:  rep = 3'd4;
         default:       rep = 3'd1;
      endcase
      return rep;
   endfunction

endpackage

FILE: rtl/voice_program_word_decoder.sv
// voice_program_word_decoder: top level; skips start-up bytes, gathers groups, decodes words
// depends on vpwd_pkg and vpwd_decode
// throughput: one bus byte per cycle unless req_stall is high; one result transaction
// per eight programming bytes, each word held in the word register, then the result register
// a stalled result holds the word register; input stalls only when both are full and blocked
// reset: synchronous, active high; clears the skip count, group index and both valid flags
// a skip_bytes write reloads the skip count; the configuration port is always ready
module voice_program_word_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_bus_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_voice_number,
   output logic        rsp_voice_active,
   output logic [5:0]  rsp_attenuation,
   output logic [7:0]  rsp_pitch_code,
   output logic [3:0]  rsp_interpolation,
   output logic [1:0]  rsp_output_pins,
   output logic [12:0] rsp_first_start,
   output logic [11:0] rsp_first_length,
   output logic [2:0]  rsp_first_repeat,
   output logic [12:0] rsp_second_start,
   output logic [11:0] rsp_second_length,
   output logic [2:0]  rsp_second_repeat
);
   import vpwd_pkg::*;

   localparam int GATHER_W = WORD_W - GROUP_W;

   logic [7:0]          skip_left_ff, skip_left_in;
   logic [2:0]          byte_index_ff, byte_index_in;
   logic [GATHER_W-1:0] gathered_ff, gathered_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                word_vld_ff, word_vld_in;
   rsp_fields_type      rsp_ff, rsp_in;
   logic                rsp_vld_ff, rsp_vld_in;

   logic                req_accept;
   logic                out_free;
   logic                word_move;
   logic                word_done;
   logic [GROUP_W-1:0]  data;
   rsp_fields_type      decoded;

   // handshakes
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_vld_ff || !rsp_stall;
   assign word_move  = word_vld_ff && out_free;
   assign req_stall  = word_vld_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign data       = req_bus_byte[GROUP_W-1:0];
   assign word_done  = req_accept && (skip_left_ff == 8'd0) && (byte_index_ff == 3'd7);

   // skip counter and group index
   always_comb begin
      skip_left_in  = skip_left_ff;
      byte_index_in = byte_index_ff;
      if (csr_valid && csr_ready) begin
         skip_left_in = csr_write_data;
      end else if (req_accept && skip_left_ff != 8'd0) begin
         skip_left_in = skip_left_ff - 8'd1;
      end
      if (req_accept && skip_left_ff == 8'd0) begin
         byte_index_in = byte_index_ff + 3'd1;
      end
   end

   // group gathering and word register
   always_comb begin
      gathered_in = gathered_ff;
      word_in     = word_ff;
      word_vld_in = word_vld_ff;
      if (req_accept && skip_left_ff == 8'd0 && byte_index_ff != 3'd7) begin
         gathered_in[byte_index_ff*GROUP_W +: GROUP_W] = data;
      end
      if (word_move) begin
         word_vld_in = 1'b0;
      end
      if (word_done) begin
         word_in     = {data, gathered_ff};
         word_vld_in = 1'b1;
      end
   end

   vpwd_decode u_decode (
      .word   (word_ff),
      .fields (decoded)
   );

   // result register
   always_comb begin
      rsp_in     = rsp_ff;
      rsp_vld_in = rsp_vld_ff;
      if (out_free) begin
         rsp_vld_in = word_vld_ff;
         if (word_vld_ff) begin
            rsp_in = decoded;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_left_ff  <= 8'd0;
         byte_index_ff <= 3'd0;
         word_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         skip_left_ff  <= skip_left_in;
         byte_index_ff <= byte_index_in;
         word_vld_ff   <= word_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      gathered_ff <= gathered_in;
      word_ff     <= word_in;
      rsp_ff      <= rsp_in;
   end

   // result ports
   assign rsp_valid         = rsp_vld_ff;
   assign rsp_voice_number  = rsp_ff.voice_number;
   assign rsp_voice_active  = rsp_ff.voice_active;
   assign rsp_attenuation   = rsp_ff.attenuation;
   assign rsp_pitch_code    = rsp_ff.pitch_code;
   assign rsp_interpolation = rsp_ff.interpolation;
   assign rsp_output_pins   = rsp_ff.output_pins;
   assign rsp_first_start   = rsp_ff.first_start;
   assign rsp_first_length  = rsp_ff.first_length;
   assign rsp_first_repeat  = rsp_ff.first_repeat;
   assign rsp_second_start  = rsp_ff.second_start;
   assign rsp_second_length = rsp_ff.second_length;
   assign rsp_second_repeat = rsp_ff.second_repeat;

   // a word that moves on always shows up as a result transaction
   a_word_to_rsp: assert property (@(posedge clock) disable iff (reset)
      word_move |=> rsp_vld_ff)
      else $error("word lost between word and result register");

   // skipped bytes leave the group index alone
   a_skip_holds_index: assert property (@(posedge clock) disable iff (reset)
      (req_accept && skip_left_ff != 8'd0) |=> $stable(byte_index_ff))
      else $error("group index moved on a skipped byte");

   // a completed word never overwrites a word still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      word_done |-> (!word_vld_ff || out_free))
      else $error("word register overwritten");

   // table fields follow the active flag
   a_inactive_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && !rsp_ff.voice_active) |->
         (rsp_ff.first_length == 12'd0 && rsp_ff.second_length == 12'd0 &&
          rsp_ff.first_repeat == 3'd0 && rsp_ff.second_repeat == 3'd0))
      else $error("inactive voice carries table fields");

   a_active_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.voice_active) |->
         (rsp_ff.first_length != 12'd0 && rsp_ff.second_length != 12'd0))
      else $error("active voice with empty table");

endmodule

FILE: rtl/vpwd_decode.sv
// vpwd_decode: combinational decode of one gathered 48-bit programming word
// depends on vpwd_pkg (result struct, codes, length and repeat tables)
module vpwd_decode (
   input  logic [vpwd_pkg::WORD_W-1:0] word,
   output vpwd_pkg::rsp_fields_type    fields
);
   import vpwd_pkg::*;

   logic [5:0]  grp [GROUP_COUNT];
   logic [7:0]  addr_one;
   logic [7:0]  addr_two;
   logic [2:0]  meth;
   logic [2:0]  lcode;
   logic [7:0]  freq;
   logic        active;
   logic [11:0] l1;
   logic [11:0] l2;

   // start address: aligned to the table length, short tables offset by 16
   function automatic logic [12:0] table_start(input logic [7:0] addr, input logic [11:0] len);
      logic [12:0] start;
      start = {addr, 5'b0} & ~({1'b0, len} - 13'd1);
      if (len == LEN_SHORT) begin
         start = start | START_SHORT_OR;
      end
      return start;
   endfunction

   // split the word into its groups
   always_comb begin
      for (int k = 0; k < GROUP_COUNT; k++) begin
         grp[k] = word[k*GROUP_W +: GROUP_W];
      end
   end

   // field extraction
   assign addr_two = {grp[1][1:0], grp[2]};
   assign addr_one = {grp[1][3:2], grp[3]};
   assign meth     = grp[4][2:0];
   assign lcode    = grp[4][5:3];
   assign freq     = {grp[7], grp[6][1:0]};
   assign active   = !(freq >= FREQ_SPECIAL && freq != FREQ_ORDINARY) &&
                     (grp[0] != ATTEN_SILENT);
   assign l1       = len_one(meth, lcode);
   assign l2       = len_two(meth, lcode);

   // result assembly, table fields cleared for an inactive voice
   always_comb begin
      fields               = '0;
      fields.voice_number  = grp[6][5:2];
      fields.voice_active  = active;
      fields.attenuation   = grp[0];
      fields.interpolation = grp[5][5:2];
      fields.output_pins   = grp[1][5:4];
      fields.pitch_code    = freq;
      if (active) begin
         if (grp[5][0]) begin
            fields.pitch_code = {1'b0, freq[7:1]};
         end
         fields.first_start   = table_start(addr_one, l1);
         fields.first_length  = l1;
         fields.first_repeat  = rep_one(meth);
         fields.second_start  = table_start(addr_two, l2);
         fields.second_length = l2;
         fields.second_repeat = rep_two(meth);
      end
   end

endmodule
